### src/crcbrc_pkg.sv
// crcbrc_pkg: shared types, constants and the crc-32 byte update for the
// record checker. No dependencies.

package crcbrc_pkg;

    // record header layout and crc constants
    localparam int unsigned HDR_BYTES = 12;
    localparam logic [31:0] REC_MAGIC = 32'h424C_4143;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_SIZE    = 2'd1;
    localparam logic [1:0] STATUS_VERSION = 2'd2;
    localparam logic [1:0] STATUS_CRC     = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_LENGTH  = 2'd1;

    // summary queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    // per-record summary handed from front to back
    typedef struct packed {
        logic        size_err;
        logic [15:0] hdr_version;
        logic [15:0] hdr_length;
        logic [31:0] hdr_crc;
        logic [31:0] crc;
    } rec_sum_t;

    // reflected crc-32 update over one byte, eight shift steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

### src/crcbrc_front.sv
// crcbrc_front: takes record bytes, captures the header, runs the payload
// crc and builds a record summary on the last byte. Depends on crcbrc_pkg.

module crcbrc_front
    import crcbrc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       sum_push,
    output rec_sum_t   sum_data
);

    localparam int unsigned COUNT_SAT = HDR_BYTES + MAX_PAYLOAD + 1;
    localparam int unsigned CNT_W     = $clog2(COUNT_SAT + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [31:0]      crc_reg;
    logic [31:0]      crc_next;
    logic [31:0]      crc_upd;
    logic [31:0]      magic_reg;
    logic [15:0]      version_reg;
    logic [15:0]      length_reg;
    logic [31:0]      hcrc_reg;
    logic             too_long;
    logic             too_short;
    logic             frame_bad;

    // saturating byte count and payload crc
    always_comb
    begin
        crc_upd    = crc_byte(crc_reg, data_byte);
        count_next = count_reg;
        crc_next   = crc_reg;
        if (byte_en)
        begin
            if (32'(count_reg) < COUNT_SAT)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (32'(count_reg) >= HDR_BYTES)
            begin
                crc_next = crc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= CRC_ONES;
        end
        else if (byte_en && last_byte)
        begin
            count_reg <= '0;
            crc_reg   <= CRC_ONES;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    // header capture, each header byte lands once per record
    always_ff @(posedge clk)
    begin
        if (byte_en)
        begin
            if (32'(count_reg) < 4)
            begin
                magic_reg[8*count_reg[1:0] +: 8] <= data_byte;
            end
            else if (32'(count_reg) < 6)
            begin
                version_reg[8*count_reg[0] +: 8] <= data_byte;
            end
            else if (32'(count_reg) < 8)
            begin
                length_reg[8*count_reg[0] +: 8] <= data_byte;
            end
            else if (32'(count_reg) < HDR_BYTES)
            begin
                hcrc_reg[8*count_reg[1:0] +: 8] <= data_byte;
            end
        end
    end

    // size and framing checks on the final count
    always_comb
    begin
        too_long  = 32'(count_next) > (HDR_BYTES + MAX_PAYLOAD);
        too_short = 32'(count_next) < HDR_BYTES;
        frame_bad = (magic_reg != REC_MAGIC)
                 || (32'(count_next) != (32'(length_reg) + HDR_BYTES));
    end

    // summary for the back end
    assign sum_push             = byte_en && last_byte;
    assign sum_data.size_err    = too_long || too_short || frame_bad;
    assign sum_data.hdr_version = version_reg;
    assign sum_data.hdr_length  = length_reg;
    assign sum_data.hdr_crc     = hcrc_reg;
    assign sum_data.crc         = ~crc_next;

endmodule

### src/crcbrc_queue.sv
// crcbrc_queue: short queue of record summaries between front and back.
// Depends on crcbrc_pkg.

module crcbrc_queue
    import crcbrc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  rec_sum_t push_data,
    input  logic     pop,
    output rec_sum_t head_data,
    output logic     q_full,
    output logic     q_empty
);

    rec_sum_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   wptr_next;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W-1:0]   rptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign q_full    = (32'(count_reg) == QUEUE_DEPTH);
    assign q_empty   = (count_reg == '0);
    assign do_push   = push && !q_full;
    assign do_pop    = pop && !q_empty;
    assign head_data = slot_reg[rptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (32'(wptr_reg) == QUEUE_DEPTH - 1) ? '0 : wptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (32'(rptr_reg) == QUEUE_DEPTH - 1) ? '0 : rptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    // occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= QUEUE_DEPTH)
        else $error("summary queue over depth");

    // empty queue has aligned pointers
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("pointers differ while queue empty");

    // a lone push grows the occupancy by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("push did not grow queue");

endmodule

### src/crcbrc_back.sv
// crcbrc_back: decides the record status from a summary and the expected
// values, and holds the result register. Depends on crcbrc_pkg.

module crcbrc_back
    import crcbrc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] expected_version,
    input  logic [8:0]  expected_length,
    input  logic        head_valid,
    input  rec_sum_t    head_data,
    output logic        head_pop,
    input  logic        pop,
    output logic        empty,
    output logic [1:0]  status,
    output logic [31:0] computed_crc
);

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] crc_reg;
    logic [1:0]  status_next;
    logic        bad_expected;

    // status in priority order
    always_comb
    begin
        bad_expected = (expected_length == '0)
                    || (32'(expected_length) > MAX_PAYLOAD);
        if (bad_expected || head_data.size_err)
        begin
            status_next = STATUS_SIZE;
        end
        else if (head_data.hdr_version != expected_version)
        begin
            status_next = STATUS_VERSION;
        end
        else if (head_data.hdr_length != 16'(expected_length))
        begin
            status_next = STATUS_SIZE;
        end
        else if (head_data.crc != head_data.hdr_crc)
        begin
            status_next = STATUS_CRC;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    // load a new result when the register is free or being taken
    assign head_pop = head_valid && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (head_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            status_reg <= status_next;
            crc_reg    <= head_data.crc;
        end
    end

    assign empty        = !out_valid_reg;
    assign status       = status_reg;
    assign computed_crc = crc_reg;

endmodule

### src/crc32_blob_record_checker_unit.sv
// crc32_blob_record_checker_unit: top level of the record checker, holds the
// configuration registers. Depends on crcbrc_pkg, crcbrc_front, crcbrc_queue,
// crcbrc_back.
//
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------
//  input     push / full                data_byte[7:0], last_byte
//  result    pop / empty                status[1:0], computed_crc[31:0]
//  config    cfg_valid / cfg_ready      cfg_index[1:0], cfg_data[15:0]
//
//  one byte per cycle unless the queue is full; header capture and eight-bit
//  crc update sit in a single front stage. a result passes a queue entry, then
//  the result register. the two-entry summary queue and the result register
//  let input keep flowing while results wait. reset clears counters, crc and
//  queue state at once; no clearing pass. cfg_ready is always high.

module crc32_blob_record_checker_unit
    import crcbrc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic                 pop,
    output logic                 empty,
    output logic [1:0]           status,
    output logic [31:0]          computed_crc,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    logic [15:0] exp_version_reg;
    logic [8:0]  exp_length_reg;
    logic        byte_en;
    logic        sum_push;
    rec_sum_t    sum_data;
    rec_sum_t    head_data;
    logic        q_full;
    logic        q_empty;
    logic        head_pop;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_version_reg <= 16'd0;
            exp_length_reg  <= 9'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EXPECTED_VERSION: exp_version_reg <= cfg_data;
                REG_EXPECTED_LENGTH:  exp_length_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // input transaction
    assign full    = q_full;
    assign byte_en = push && !q_full;

    crcbrc_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .sum_push  (sum_push),
        .sum_data  (sum_data)
    );

    crcbrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (sum_push),
        .push_data (sum_data),
        .pop       (head_pop),
        .head_data (head_data),
        .q_full    (q_full),
        .q_empty   (q_empty)
    );

    crcbrc_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .expected_version (exp_version_reg),
        .expected_length  (exp_length_reg),
        .head_valid       (!q_empty),
        .head_data        (head_data),
        .head_pop         (head_pop),
        .pop              (pop),
        .empty            (empty),
        .status           (status),
        .computed_crc     (computed_crc)
    );

endmodule

### verif/crc32_blob_record_checker_unit_test.sv
// crc32_blob_record_checker_unit_test: self-checking bench for the record checker,
// streams framed records byte by byte and checks status and crc of every record.
// Depends on crcbrc_pkg and crc32_blob_record_checker_unit.
`timescale 1ns / 1ps

module crc32_blob_record_checker_unit_test;
    import crcbrc_pkg::*;

    localparam int unsigned MAX_PAYLOAD = 256;
    localparam int unsigned COUNT_SAT   = HDR_BYTES + MAX_PAYLOAD + 1;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          MAX_REPORTS = 10;

    // indexes past the two registers, writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // what one finished record should report
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] crc;
    } record_verdict_t;

    // predictor of the checker plus the store of pending verdicts
    class record_scoreboard;
        int unsigned       byte_count;
        logic [31:0]       hdr_magic;
        logic [15:0]       hdr_version;
        logic [15:0]       hdr_length;
        logic [31:0]       hdr_crc;
        logic [31:0]       crc_acc;
        logic [15:0]       exp_version;
        logic [8:0]        exp_length;
        record_verdict_t   verdicts[$];
        int                fail_count;

        function new();
            exp_version = '0;
            exp_length  = 9'd1;
            fail_count  = 0;
            clear_record();
        endfunction

        // reflected crc-32, one bit per shift
        static function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function void clear_record();
            byte_count  = 0;
            hdr_magic   = '0;
            hdr_version = '0;
            hdr_length  = '0;
            hdr_crc     = '0;
            crc_acc     = CRC_ONES;
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
            case (idx)
                REG_EXPECTED_VERSION: exp_version = value;
                REG_EXPECTED_LENGTH:  exp_length  = value[8:0];
                default: ;
            endcase
        endfunction

        // one accepted input transaction
        function void absorb_byte(logic [7:0] b, logic last);
            int unsigned     idx;
            int unsigned     total;
            logic [31:0]     crc;
            record_verdict_t v;
            idx = byte_count;
            if (idx < 4)
                hdr_magic[8*idx +: 8] = b;
            else if (idx < 6)
                hdr_version[8*(idx-4) +: 8] = b;
            else if (idx < 8)
                hdr_length[8*(idx-6) +: 8] = b;
            else if (idx < HDR_BYTES)
                hdr_crc[8*(idx-8) +: 8] = b;
            else
                crc_acc = crc_update(crc_acc, b);
            if (byte_count < COUNT_SAT)
                byte_count++;
            if (!last)
                return;

            total = byte_count;
            crc   = ~crc_acc;
            if (exp_length == 0 || exp_length > MAX_PAYLOAD)
                v.status = STATUS_SIZE;
            else if (total > HDR_BYTES + MAX_PAYLOAD)
                v.status = STATUS_SIZE;
            else if (total < HDR_BYTES)
                v.status = STATUS_SIZE;
            else if (hdr_magic != REC_MAGIC || total != HDR_BYTES + hdr_length)
                v.status = STATUS_SIZE;
            else if (hdr_version != exp_version)
                v.status = STATUS_VERSION;
            else if (hdr_length != {7'd0, exp_length})
                v.status = STATUS_SIZE;
            else if (crc != hdr_crc)
                v.status = STATUS_CRC;
            else
                v.status = STATUS_OK;
            v.crc = crc;
            verdicts.push_back(v);
            clear_record();
        endfunction

        // one accepted result transaction
        function void check_verdict(logic [1:0] st, logic [31:0] crc);
            record_verdict_t v;
            if (verdicts.size() == 0) begin
                flag($sformatf("result with nothing pending: status %0d crc %h", st, crc));
                return;
            end
            v = verdicts.pop_front();
            if (st !== v.status)
                flag($sformatf("status expected %0d actual %0d", v.status, st));
            if (crc !== v.crc)
                flag($sformatf("computed_crc expected %h actual %h", v.crc, crc));
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [7:0]           data_byte = '0;
    logic                 last_byte = 1'b0;
    logic                 pop = 1'b0;
    logic                 empty;
    logic [1:0]           status;
    logic [31:0]          computed_crc;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    record_scoreboard sb;
    logic [7:0]       rec_q[$];
    int               send_idle = 0;
    int               recv_idle = 0;
    logic [15:0]      cur_version = '0;
    int               cur_length = 1;
    int               cycles = 0;

    crc32_blob_record_checker_unit #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .pop          (pop),
        .empty        (empty),
        .status       (status),
        .computed_crc (computed_crc),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check accepted transactions, stall at random
    initial
    begin
        sb = new();
        forever begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_verdict(status, computed_crc);
            pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // header little-endian, then payload; crc_flip corrupts the stored crc
    function automatic void make_record(logic [31:0] magic, logic [15:0] ver,
                                        logic [15:0] len_field, int n_payload,
                                        logic [31:0] crc_flip, int fill);
        logic [31:0] c;
        logic [7:0]  p[$];
        logic [7:0]  b;
        c = CRC_ONES;
        for (int i = 0; i < n_payload; i++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            p.push_back(b);
            c = record_scoreboard::crc_update(c, b);
        end
        c = ~c ^ crc_flip;
        rec_q = {};
        for (int k = 0; k < 4; k++) rec_q.push_back(magic[8*k +: 8]);
        for (int k = 0; k < 2; k++) rec_q.push_back(ver[8*k +: 8]);
        for (int k = 0; k < 2; k++) rec_q.push_back(len_field[8*k +: 8]);
        for (int k = 0; k < 4; k++) rec_q.push_back(c[8*k +: 8]);
        foreach (p[i]) rec_q.push_back(p[i]);
    endfunction

    // mostly well-formed records, the rest broken frames and noise
    task automatic build_random_record();
        int plen;
        int shape;
        int n;
        plen = (cur_length >= 1 && cur_length <= MAX_PAYLOAD) ? cur_length
                                                             : $urandom_range(0, 8);
        shape = $urandom_range(0, 99);
        if (shape < 55)
            make_record(REC_MAGIC, cur_version, 16'(plen), plen, '0, -1);
        else if (shape < 62)
            make_record(REC_MAGIC, cur_version, 16'(plen), plen,
                        32'd1 << $urandom_range(0, 31), -1);
        else if (shape < 68)
            make_record(REC_MAGIC, cur_version ^ 16'($urandom_range(1, 65535)),
                        16'(plen), plen, '0, -1);
        else if (shape < 73)
            make_record(REC_MAGIC ^ (32'd1 << $urandom_range(0, 31)), cur_version,
                        16'(plen), plen, '0, -1);
        else if (shape < 79) begin
            // consistent frame, length other than expected
            n = (plen + $urandom_range(1, 3)) % 257;
            make_record(REC_MAGIC, cur_version, 16'(n), n, '0, -1);
        end
        else if (shape < 85) begin
            // payload count disagrees with the header length
            if (plen > 0 && $urandom_range(0, 1))
                n = plen - $urandom_range(1, (plen < 3) ? plen : 3);
            else
                n = plen + $urandom_range(1, 3);
            make_record(REC_MAGIC, cur_version, 16'(plen), n, '0, -1);
        end
        else if (shape < 92) begin
            // cut inside the header
            make_record(REC_MAGIC, cur_version, 16'(plen), plen, '0, -1);
            n = $urandom_range(1, 11);
            while (rec_q.size() > n) void'(rec_q.pop_back());
        end
        else if (shape < 99) begin
            rec_q = {};
            n = $urandom_range(1, 24);
            repeat (n) rec_q.push_back(8'($urandom));
        end
        else
            make_record(REC_MAGIC, cur_version, 16'($urandom),
                        $urandom_range(257, 259), '0, -1);
    endtask

    // one input transaction, push stays high for a following byte
    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.absorb_byte(b, last);
    endtask

    task automatic send_record();
        for (int i = 0; i < rec_q.size(); i++)
            send_byte(rec_q[i], i == rec_q.size() - 1);
    endtask

    // cfg_valid is left high; the caller lowers it after the last write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    // all verdicts in, plus room for the pipeline to settle
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_phase(input int s_idle, input int r_idle,
                             input logic [15:0] ver_data, input logic [15:0] len_data,
                             input int budget);
        int sent;
        wait_drained();
        send_idle = s_idle;
        recv_idle = r_idle;
        write_register(REG_SPARE_A, 16'($urandom));
        write_register(REG_SPARE_B, 16'($urandom));
        write_register(REG_EXPECTED_VERSION, ver_data);
        write_register(REG_EXPECTED_LENGTH, len_data);
        cfg_valid   <= 1'b0;
        cur_version = ver_data;
        cur_length  = int'(len_data[8:0]);
        sent = 0;
        while (sent < budget) begin
            build_random_record();
            sent += rec_q.size();
            send_record();
        end
        push <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 26;
        recv_idle = 59;

        // directed records under reset settings: version 0, length 1
        make_record(REC_MAGIC, 16'h0000, 16'd1, 1, '0, 8'h00);
        send_record();
        make_record(REC_MAGIC, 16'h0000, 16'd1, 1, '0, 8'hFF);
        send_record();
        make_record(REC_MAGIC, 16'h0000, 16'd1, 1, 32'h8000_0000, -1);
        send_record();
        make_record(REC_MAGIC, 16'hFFFF, 16'd1, 1, '0, -1);
        send_record();
        make_record(~REC_MAGIC, 16'h0000, 16'd1, 1, '0, -1);
        send_record();
        // single-byte record
        rec_q = {8'hFF};
        send_record();
        // record ending one byte short of the header
        make_record(REC_MAGIC, 16'h0000, 16'd1, 1, '0, -1);
        while (rec_q.size() > 11) void'(rec_q.pop_back());
        send_record();
        // header only, no payload
        make_record(REC_MAGIC, 16'h0000, 16'd0, 0, '0, -1);
        send_record();
        // well framed, length differs from expected
        make_record(REC_MAGIC, 16'h0000, 16'd2, 2, '0, -1);
        send_record();
        // total count differs from header length
        make_record(REC_MAGIC, 16'h0000, 16'd1, 3, '0, -1);
        send_record();
        // overlong record, byte counter saturates
        make_record(REC_MAGIC, 16'h0000, 16'hFFFF, 260, '0, -1);
        send_record();
        push <= 1'b0;

        // random phases over several register settings
        run_phase(26, 59, 16'($urandom), {7'($urandom), 9'($urandom_range(1, 8))}, 150);
        run_phase(26, 59, 16'hFFFF, 16'h0100, 150);
        run_phase(59, 26, 16'($urandom), 16'hFE00, 50);
        run_phase(59, 26, 16'($urandom), {7'($urandom), 9'($urandom_range(1, 12))}, 120);
        run_phase(0, 0, 16'h0000, 16'hFFFF, 40);
        run_phase(0, 0, 16'($urandom), {7'($urandom), 9'($urandom_range(1, 4))}, 120);

        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
